[sv/iss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants of the indexed sequence store
// Request and response item layouts, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_REAR  = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_REAR  = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_READ_POS  = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [6:0]  position;
		logic [31:0] new_value;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        read_valid;
		logic [6:0]  item_total;
		logic [1:0]  status;
	} rsp_item_t;

	// What the accepted request turns into once its checks have passed.
	typedef enum logic [1:0] {
		K_NONE,
		K_INS,
		K_DEL,
		K_RD
	} kind_t;

	typedef struct packed {
		logic load;
		logic move;
		logic rd_issue;
		logic put;
		logic finish;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  left_zero;
		logic  pend;
		logic  out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[sv/indexed_sequence_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_store: fixed-capacity ordered sequence of data words
// Insert, delete and read by position with element shifting; every request
// returns one response with the element count and a status code.
//
//   channel   handshake               payload
//   request   req_valid / req_ready   req_item (func, position, new_value)
//   response  rsp_valid / rsp_ready   rsp_item (read_value, read_valid,
//                                               item_total, status)
//
// Reads, rejected requests and the unused code go from load through run to done.
// Inserts and deletes stay in run until the last moved element has landed; the
// single RAM read port moves one element a cycle.
// A new request is taken while an earlier response still waits in the
// response register; only the final hand-off waits for rsp_ready.
// Reset clears the element count; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
	parameter int CAPACITY   = iss_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = iss_pkg::DEF_DATA_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire iss_pkg::req_item_t req_item,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output iss_pkg::rsp_item_t      rsp_item
);

	iss_pkg::cmd_t     cmd;
	iss_pkg::dp_stat_t stat;

	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iss_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_item  (req_item),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

endmodule
`default_nettype wire

[sv/iss_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iss_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[sv/iss_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iss_ctrl: controller of the indexed sequence store
// Sequences request load, element moves, the final write or read, and the
// hand-off of the result into the response register.
// ----------------------------------------------------------------------------
module iss_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire iss_pkg::dp_stat_t stat,
	output iss_pkg::cmd_t          cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				case (stat.kind)
					iss_pkg::K_RD: begin
						cmd.rd_issue = 1'b1;
						state_d      = S_DONE;
					end
					iss_pkg::K_INS, iss_pkg::K_DEL: begin
						if (stat.left_zero && !stat.pend) begin
							// The new word goes in only after the last moved element landed.
							cmd.put = (stat.kind == iss_pkg::K_INS);
							state_d = S_DONE;
						end else begin
							cmd.move = 1'b1;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_move_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !stat.pend)
		else $error("element move still pending while idle");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !stat.out_free) |=> (state_q == S_DONE))
		else $error("result left done state while response register was busy");
`endif

endmodule
`default_nettype wire

[sv/iss_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iss_dp: datapath of the indexed sequence store
// Request checks, element count, element RAM with its move pipeline, and
// the response register.
// ----------------------------------------------------------------------------
module iss_dp #(
	parameter int CAPACITY   = iss_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = iss_pkg::DEF_DATA_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire iss_pkg::cmd_t      cmd,
	output iss_pkg::dp_stat_t       stat,
	input  wire iss_pkg::req_item_t req_item,
	input  wire logic               rsp_ready,
	output logic                    rsp_valid,
	output iss_pkg::rsp_item_t      rsp_item
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > 7) ? CW : 7;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         left_q;
	iss_pkg::kind_t        kind_q;
	logic [1:0]            status_q;
	logic [AW-1:0]         at_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic                  pend_s1;
	logic [AW-1:0]         wa_s1;
	logic                  rsp_valid_q;

	iss_pkg::kind_t        kind_d;
	logic [1:0]            status_d;
	logic [IW-1:0]         pos_w;
	logic [IW-1:0]         cnt_w;
	logic [IW-1:0]         at_w;
	logic [IW-1:0]         mov_w;
	logic [IW-1:0]         start_w;
	logic [DATA_WIDTH+31:0] word_ext;
	logic [DATA_WIDTH+31:0] rd_ext;
	logic [CW+6:0]         tot_ext;
	logic                  issue;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	// Request checks against the current count.
	always_comb begin
		pos_w    = IW'(req_item.position);
		cnt_w    = IW'(count_q);
		kind_d   = iss_pkg::K_NONE;
		status_d = iss_pkg::ST_OK;
		case (req_item.func)
			iss_pkg::OP_INS_FRONT, iss_pkg::OP_DEL_FRONT: at_w = '0;
			iss_pkg::OP_INS_REAR:                         at_w = cnt_w;
			iss_pkg::OP_DEL_REAR:                         at_w = cnt_w - IW'(1);
			default:                                      at_w = pos_w;
		endcase
		if (req_item.func inside {iss_pkg::OP_INS_FRONT, iss_pkg::OP_INS_REAR,
				iss_pkg::OP_INS_POS}) begin
			if (cnt_w >= IW'(CAPACITY)) begin
				status_d = iss_pkg::ST_FULL;
			end else if (at_w > cnt_w) begin
				status_d = iss_pkg::ST_RANGE;
			end else begin
				kind_d = iss_pkg::K_INS;
			end
		end else if (req_item.func inside {iss_pkg::OP_DEL_FRONT, iss_pkg::OP_DEL_REAR,
				iss_pkg::OP_DEL_POS}) begin
			if (cnt_w == '0) begin
				status_d = iss_pkg::ST_EMPTY;
			end else if (at_w >= cnt_w) begin
				status_d = iss_pkg::ST_RANGE;
			end else begin
				kind_d = iss_pkg::K_DEL;
			end
		end else if (req_item.func == iss_pkg::OP_READ_POS) begin
			if (pos_w < cnt_w) begin
				kind_d = iss_pkg::K_RD;
			end else begin
				status_d = iss_pkg::ST_RANGE;
			end
		end
		// Inserts walk down from the last element, deletes walk up past the hole.
		if (kind_d == iss_pkg::K_INS) begin
			mov_w   = cnt_w - at_w;
			start_w = cnt_w - IW'(1);
		end else begin
			mov_w   = cnt_w - at_w - IW'(1);
			start_w = at_w + IW'(1);
		end
	end

	assign word_ext = {{DATA_WIDTH{1'b0}}, req_item.new_value};

	assign issue   = cmd.move && (left_q != '0);
	assign wr_en   = pend_s1 || cmd.put;
	assign wr_addr = cmd.put ? at_q : wa_s1;
	assign wr_data = cmd.put ? word_q : rd_data;
	assign rd_en   = issue || cmd.rd_issue;
	assign rd_addr = cmd.rd_issue ? at_q : rd_ptr_q;

	iss_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		case (kind_q)
			iss_pkg::K_INS: count_d = count_q + CW'(1);
			iss_pkg::K_DEL: count_d = count_q - CW'(1);
			default:        count_d = count_q;
		endcase
	end

	assign tot_ext = {7'b0, count_d};
	assign rd_ext  = {32'b0, rd_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			kind_q      <= iss_pkg::K_NONE;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.load) begin
				kind_q <= kind_d;
				left_q <= CW'(mov_w);
			end else if (issue) begin
				left_q <= left_q - CW'(1);
			end
			if (cmd.finish) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= status_d;
			at_q     <= at_w[AW-1:0];
			rd_ptr_q <= start_w[AW-1:0];
			word_q   <= word_ext[DATA_WIDTH-1:0];
		end else if (issue) begin
			if (kind_q == iss_pkg::K_INS) begin
				rd_ptr_q <= rd_ptr_q - AW'(1);
			end else begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
		end
		if (issue) begin
			wa_s1 <= (kind_q == iss_pkg::K_INS) ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
		end
		if (cmd.finish) begin
			rsp_item.read_value <= (kind_q == iss_pkg::K_RD) ? rd_ext[31:0] : 32'd0;
			rsp_item.read_valid <= (kind_q == iss_pkg::K_RD);
			rsp_item.item_total <= tot_ext[6:0];
			rsp_item.status     <= status_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign stat.kind      = kind_q;
	assign stat.left_zero = (left_q == '0);
	assign stat.pend      = pend_s1;
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

`ifndef NO_ASSERTIONS
	a_put_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !pend_s1)
		else $error("insert write collided with a pending element move");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwrote an untaken response");
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && (kind_q == iss_pkg::K_INS)) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not raise the element count by one");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (count_q <= CW'(CAPACITY)))
		else $error("element count beyond capacity");
`endif

endmodule
`default_nettype wire
